// ===== hdl/ptst_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and types of the periodic timer slot table.
package ptst_pkg;

  // Default values for the top-level parameters.
  localparam int SLOTS_DEF       = 8;
  localparam int TICK_MS_DEF     = 1000;
  localparam int PERIOD_BITS_DEF = 32;

  // Fixed port widths.
  localparam int MODE_W   = 2;
  localparam int PERIOD_W = 32;
  localparam int SID_W    = 8;
  localparam int SLOT_W   = 3;

  // Countdown and reload width, and its saturation value.
  localparam int CD_W = 23;
  localparam logic [CD_W-1:0] CD_MAX = {CD_W{1'b1}};

  // Expired counter.
  localparam int CNT_W = 4;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Most fires one service item may emit.
  localparam int MAX_FIRES = 8;
  localparam int FIRE_W    = 3;

  // Slot index carried along the cell chain, wide enough for the largest table.
  localparam int IDX_W = 6;

  // Item modes, echoed as result kinds.
  localparam logic [MODE_W-1:0] MODE_ARM     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DISARM  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SERVICE = 2'd3;

  // Slot status codes.
  localparam logic [1:0] ST_FREE    = 2'd0;
  localparam logic [1:0] ST_ARMED   = 2'd1;
  localparam logic [1:0] ST_EXPIRED = 2'd2;

  // Operation broadcast to every cell.
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_TICK,
    OP_ARM,
    OP_DISARM,
    OP_FIRE,
    OP_COUNT
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic               take;   // commit the operation this cycle
    logic               flush;  // drop every pending expiry mark
    logic [CD_W-1:0]    load;   // reload value for arm
    logic [SID_W-1:0]   sid;    // slot targeted by disarm
  } cell_cmd_t;

  // Search result handed from cell to cell.
  typedef struct packed {
    logic             hit;   // some earlier cell matched
    logic             more;  // a further cell matched after the winner
    logic [IDX_W-1:0] idx;   // index of the first matching cell
  } chain_t;

endpackage

// ===== hdl/periodic_timer_slot_table_core.sv =====
`timescale 1ns / 1ps
// Top level of the periodic timer slot table.
// Arm divides the period by a registered reciprocal multiply, then claims a slot; disarm frees
//   the named slot; tick marks and counts expiries; service fires one per cycle, up to 8.
// Throughput: one item in work at a time; the input reopens the cycle after the last result
//   is registered, and a stalled result channel holds the sequencer.
// Synchronous reset frees every slot and clears countdowns and the expired count.
module periodic_timer_slot_table_core #(
  parameter int SLOTS       = ptst_pkg::SLOTS_DEF,
  parameter int TICK_MS     = ptst_pkg::TICK_MS_DEF,
  parameter int PERIOD_BITS = ptst_pkg::PERIOD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ptst_pkg::MODE_W-1:0]   mode,
  input  logic [ptst_pkg::PERIOD_W-1:0] period_ms,
  input  logic [ptst_pkg::SID_W-1:0]    slot_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ptst_pkg::MODE_W-1:0]   kind,
  output logic [ptst_pkg::SLOT_W-1:0]   slot,
  output logic                          ok,
  output logic                          fired,
  output logic                          any_expired,
  output logic                          last
);

  // Dividend width: the period field masked to PERIOD_BITS.
  localparam int DW = (PERIOD_BITS < ptst_pkg::PERIOD_W) ? PERIOD_BITS : ptst_pkg::PERIOD_W;
  localparam int QW = (DW > ptst_pkg::CD_W) ? DW : ptst_pkg::CD_W;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_ARM  = 3'd2;
  localparam logic [2:0] S_DIS  = 3'd3;
  localparam logic [2:0] S_TICK = 3'd4;
  localparam logic [2:0] S_CNT  = 3'd5;
  localparam logic [2:0] S_SRV  = 3'd6;

  logic [2:0]                    state, state_next;
  logic [ptst_pkg::SID_W-1:0]    sid;
  logic [ptst_pkg::CNT_W-1:0]    cnt, cnt_next;
  logic [ptst_pkg::FIRE_W-1:0]   nfire, nfire_next;

  logic                          in_fire;
  logic                          out_free;
  logic                          emit;
  logic [ptst_pkg::MODE_W-1:0]   emit_kind;
  logic [ptst_pkg::SLOT_W-1:0]   emit_slot;
  logic                          emit_ok;
  logic                          emit_fired;
  logic                          emit_last;

  logic                          div_start;
  logic                          div_busy;
  logic [DW-1:0]                 quot;
  logic [QW-1:0]                 quot_ext;
  logic [ptst_pkg::CD_W-1:0]     reload_val;
  logic [ptst_pkg::CNT_W-1:0]    cnt_dec;

  ptst_pkg::cell_cmd_t           cmd;
  ptst_pkg::chain_t              links [SLOTS+1];
  ptst_pkg::chain_t              found;

  assign in_ready = state == S_IDLE;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Period divided by the tick length through a reciprocal multiply.
  assign div_start = in_fire && (mode == ptst_pkg::MODE_ARM);

  ptst_div #(
    .DW      (DW),
    .TICK_MS (TICK_MS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (period_ms[DW-1:0]),
    .busy     (div_busy),
    .quotient (quot)
  );

  // Saturate the tick count to the countdown width.
  assign quot_ext   = QW'(quot);
  assign reload_val = (quot_ext > QW'(ptst_pkg::CD_MAX)) ? ptst_pkg::CD_MAX
                                                        : quot_ext[ptst_pkg::CD_W-1:0];

  // Row of slot cells; the search result ripples from slot 0 upward.
  assign links[0] = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    ptst_cell #(
      .IDX (g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .link_in  (links[g]),
      .link_out (links[g+1])
    );
  end

  assign found   = links[SLOTS];
  assign cnt_dec = (cnt == '0) ? '0 : cnt - 1'b1;

  // Drive the cells and decide the next result.
  always_comb begin
    cmd        = '0;
    cmd.op     = ptst_pkg::OP_IDLE;
    cmd.load   = reload_val;
    cmd.sid    = sid;
    state_next = state;
    cnt_next   = cnt;
    nfire_next = nfire;
    emit       = 1'b0;
    emit_kind  = ptst_pkg::MODE_ARM;
    emit_slot  = '0;
    emit_ok    = 1'b1;
    emit_fired = 1'b0;
    emit_last  = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          unique case (mode)
            ptst_pkg::MODE_ARM:    state_next = S_DIV;
            ptst_pkg::MODE_DISARM: state_next = S_DIS;
            ptst_pkg::MODE_TICK:   state_next = S_TICK;
            default:               state_next = S_SRV;
          endcase
        end
      end
      S_DIV: begin
        // Hold until the quotient lands.
        if (!div_busy) begin
          state_next = S_ARM;
        end
      end
      S_ARM: begin
        // Claim the lowest free slot; a full table answers ok=0.
        cmd.op   = ptst_pkg::OP_ARM;
        cmd.take = out_free;
        if (out_free) begin
          emit       = 1'b1;
          emit_kind  = ptst_pkg::MODE_ARM;
          emit_slot  = found.hit ? found.idx[ptst_pkg::SLOT_W-1:0] : '0;
          emit_ok    = found.hit;
          state_next = S_IDLE;
        end
      end
      S_DIS: begin
        // Free the slot; the chain reports whether it was expired.
        cmd.op   = ptst_pkg::OP_DISARM;
        cmd.take = out_free;
        if (out_free) begin
          if (found.hit) begin
            cnt_next = cnt_dec;
          end
          emit       = 1'b1;
          emit_kind  = ptst_pkg::MODE_DISARM;
          state_next = S_IDLE;
        end
      end
      S_TICK: begin
        // Every armed cell counts down at once and marks fresh expiries.
        cmd.op     = ptst_pkg::OP_TICK;
        cmd.take   = 1'b1;
        state_next = S_CNT;
      end
      S_CNT: begin
        // Fold fresh expiries into the counter one per cycle, stopping at saturation.
        cmd.op = ptst_pkg::OP_COUNT;
        if (found.hit && (cnt != ptst_pkg::CNT_MAX)) begin
          cmd.take = 1'b1;
          cnt_next = cnt + 1'b1;
        end else if (out_free) begin
          cmd.flush  = 1'b1;
          emit       = 1'b1;
          emit_kind  = ptst_pkg::MODE_TICK;
          state_next = S_IDLE;
        end
      end
      S_SRV: begin
        // Fire the lowest expired slot each cycle that the result channel is free, and re-arm it.
        cmd.op   = ptst_pkg::OP_FIRE;
        cmd.take = out_free;
        if (out_free) begin
          emit      = 1'b1;
          emit_kind = ptst_pkg::MODE_SERVICE;
          if (found.hit) begin
            cnt_next   = cnt_dec;
            emit_slot  = found.idx[ptst_pkg::SLOT_W-1:0];
            emit_fired = 1'b1;
            emit_last  = !found.more ||
                         (nfire == ptst_pkg::FIRE_W'(ptst_pkg::MAX_FIRES - 1));
            nfire_next = nfire + 1'b1;
          end
          if (emit_last) begin
            nfire_next = '0;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      nfire <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      nfire <= nfire_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sid <= slot_id;
    end
  end

  // Output register: load a new result, or drop the old one once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // The summary flag shows whether the expired count is nonzero as each result is loaded.
  always_ff @(posedge clk) begin
    if (emit) begin
      kind        <= emit_kind;
      slot        <= emit_slot;
      ok          <= emit_ok;
      fired       <= emit_fired;
      any_expired <= cnt_next != '0;
      last        <= emit_last;
    end
  end

endmodule

// ===== hdl/ptst_div.sv =====
`timescale 1ns / 1ps
// Division by the constant tick length through a registered reciprocal multiply.
module ptst_div #(
  parameter int DW      = 32,
  parameter int TICK_MS = 1000
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  output logic          busy,
  output logic [DW-1:0] quotient
);

  // Round-up reciprocal scaled by 2^(DW + ceil(log2 TICK_MS)); exact for every DW-bit
  // dividend. It needs DW+1 bits, so the top bit is applied as a shifted add.
  localparam int              LW       = $clog2(TICK_MS);
  localparam int              SH       = DW + LW;
  localparam longint unsigned RECIP    = ((64'd1 << SH) + 64'(TICK_MS) - 64'd1) /
                                         64'(TICK_MS);
  localparam logic [DW-1:0]   RECIP_LO = DW'(RECIP);
  localparam logic            RECIP_HI = ((RECIP >> DW) != 64'd0);

  logic [2*DW-1:0] mul_lo;
  logic [2*DW-1:0] prod;
  logic [DW-1:0]   dvd;
  logic [2*DW-1:0] hi_term;
  logic [2*DW:0]   sum;

  assign mul_lo  = {{DW{1'b0}}, dividend} * {{DW{1'b0}}, RECIP_LO};
  assign hi_term = RECIP_HI ? {dvd, {DW{1'b0}}} : '0;
  assign sum     = {1'b0, prod} + {1'b0, hi_term};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= start;
    end
  end

  // Register the product on start, then add the top reciprocal bit and scale down while busy.
  always_ff @(posedge clk) begin
    if (start) begin
      prod <= mul_lo;
      dvd  <= dividend;
    end
    if (busy) begin
      quotient <= DW'(sum >> SH);
    end
  end

endmodule

// ===== hdl/ptst_cell.sv =====
`timescale 1ns / 1ps
// One timer slot: status, countdown, reload and pending mark, with its chain link.
module ptst_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  ptst_pkg::cell_cmd_t cmd,
  input  ptst_pkg::chain_t    link_in,
  output ptst_pkg::chain_t    link_out
);

  logic [1:0]                status;
  logic [ptst_pkg::CD_W-1:0] cd;
  logic [ptst_pkg::CD_W-1:0] reload;
  logic                      pend;
  logic [ptst_pkg::CD_W-1:0] cd_dec;
  logic                      id_match;
  logic                      match;
  logic                      win;

  assign id_match = cmd.sid == ptst_pkg::SID_W'(IDX);
  assign cd_dec   = (cd == '0) ? '0 : cd - 1'b1;

  always_comb begin
    unique case (cmd.op)
      ptst_pkg::OP_ARM:    match = status == ptst_pkg::ST_FREE;
      ptst_pkg::OP_FIRE:   match = status == ptst_pkg::ST_EXPIRED;
      ptst_pkg::OP_COUNT:  match = pend;
      ptst_pkg::OP_DISARM: match = id_match && (status == ptst_pkg::ST_EXPIRED);
      default:             match = 1'b0;
    endcase
  end

  assign win           = match && !link_in.hit;
  assign link_out.hit  = link_in.hit | match;
  assign link_out.more = link_in.more | (link_in.hit & match);
  assign link_out.idx  = win ? ptst_pkg::IDX_W'(IDX) : link_in.idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= ptst_pkg::ST_FREE;
      cd     <= '0;
      pend   <= 1'b0;
    end else if (cmd.take) begin
      unique case (cmd.op)
        ptst_pkg::OP_TICK: begin
          if (status == ptst_pkg::ST_ARMED) begin
            cd <= cd_dec;
            if (cd_dec == '0) begin
              status <= ptst_pkg::ST_EXPIRED;
              pend   <= 1'b1;
            end
          end
        end
        ptst_pkg::OP_ARM: begin
          if (win) begin
            cd     <= cmd.load;
            status <= ptst_pkg::ST_ARMED;
          end
        end
        ptst_pkg::OP_DISARM: begin
          if (id_match) begin
            status <= ptst_pkg::ST_FREE;
          end
        end
        ptst_pkg::OP_FIRE: begin
          if (win) begin
            cd     <= reload;
            status <= ptst_pkg::ST_ARMED;
          end
        end
        ptst_pkg::OP_COUNT: begin
          if (win) begin
            pend <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.flush) begin
      pend <= 1'b0;
    end
  end

  // Reload store has no reset; only armed or expired slots read it.
  always_ff @(posedge clk) begin
    if (cmd.take && (cmd.op == ptst_pkg::OP_ARM) && win) begin
      reload <= cmd.load;
    end
  end

endmodule
